// ----- sv/bls_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bresenham line stepper package
// Shared widths, beat types and the line state record.
// ----------------------------------------------------------------------------
package bls_pkg;

	localparam int COORD_BITS = 12;
	localparam int DELTA_BITS = COORD_BITS + 1;
	localparam int ERR_BITS   = COORD_BITS + 4;
	localparam int COLOR_BITS = 32;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic        [DELTA_BITS-1:0] delta_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic        [COLOR_BITS-1:0] color_t;

	typedef enum logic {
		FUNC_START   = 1'b0,
		FUNC_ADVANCE = 1'b1
	} func_t;

	typedef struct packed {
		func_t  func;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
		color_t color;
	} cmd_beat_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		color_t pixel_color;
		logic   last_pixel;
	} pixel_beat_t;

	typedef struct packed {
		coord_t cur_x;
		coord_t cur_y;
		coord_t target_x;
		coord_t target_y;
		logic   step_x_neg;
		logic   step_y_neg;
		delta_t twice_dx;
		delta_t twice_dy;
		err_t   error_term;
		logic   x_major;
		logic   active;
		color_t line_color;
	} line_state_t;

endpackage
`default_nettype wire

// ----- sv/bls_line_setup.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line setup
// Builds the line state for a start beat: deltas, step signs, major axis,
// initial error term and the end check for the first pixel.
// ----------------------------------------------------------------------------
module bls_line_setup (
	input  bls_pkg::cmd_beat_t   cmd,
	output bls_pkg::line_state_t setup,
	output logic                 last
);

	localparam int C = bls_pkg::COORD_BITS;
	localparam int E = bls_pkg::ERR_BITS;

	logic signed [C:0]   dx;
	logic signed [C:0]   dy;
	logic        [C-1:0] adx;
	logic        [C-1:0] ady;
	logic                major_x;
	bls_pkg::err_t       err_x;
	bls_pkg::err_t       err_y;

	always_comb begin
		dx  = (C+1)'(cmd.end_x) - (C+1)'(cmd.start_x);
		dy  = (C+1)'(cmd.end_y) - (C+1)'(cmd.start_y);
		adx = dx[C] ? C'(-dx) : C'(dx);
		ady = dy[C] ? C'(-dy) : C'(dy);
		major_x = adx > ady;
		err_x = signed'(E'({ady, 1'b0})) - signed'(E'(adx));
		err_y = signed'(E'({adx, 1'b0})) - signed'(E'(ady));

		last = major_x ? (cmd.start_x == cmd.end_x) : (cmd.start_y == cmd.end_y);

		setup.cur_x      = cmd.start_x;
		setup.cur_y      = cmd.start_y;
		setup.target_x   = cmd.end_x;
		setup.target_y   = cmd.end_y;
		setup.step_x_neg = dx[C];
		setup.step_y_neg = dy[C];
		setup.twice_dx   = {adx, 1'b0};
		setup.twice_dy   = {ady, 1'b0};
		setup.error_term = major_x ? err_x : err_y;
		setup.x_major    = major_x;
		setup.active     = !last;
		setup.line_color = cmd.color;
	end

endmodule
`default_nettype wire

// ----- sv/bls_step_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bresenham step
// One step along the major axis, with a minor axis step when the error term
// is not negative, and the end check on the major axis.
// ----------------------------------------------------------------------------
module bls_step_core (
	input  bls_pkg::line_state_t cur,
	output bls_pkg::line_state_t nxt,
	output logic                 last
);

	localparam int E = bls_pkg::ERR_BITS;

	logic             minor_step;
	logic             move_x;
	logic             move_y;
	bls_pkg::coord_t  x_delta;
	bls_pkg::coord_t  y_delta;
	bls_pkg::err_t    err_sub;
	bls_pkg::err_t    err_add;

	always_comb begin
		minor_step = !cur.error_term[E-1];
		move_x     = cur.x_major || minor_step;
		move_y     = !cur.x_major || minor_step;
		x_delta    = cur.step_x_neg ? '1 : bls_pkg::coord_t'(1);
		y_delta    = cur.step_y_neg ? '1 : bls_pkg::coord_t'(1);

		// Twice the major axis delta comes off on a minor step; twice the minor axis delta always goes on.
		err_sub = !minor_step ? '0 :
			signed'(E'(cur.x_major ? cur.twice_dx : cur.twice_dy));
		err_add = signed'(E'(cur.x_major ? cur.twice_dy : cur.twice_dx));

		nxt            = cur;
		nxt.cur_x      = move_x ? cur.cur_x + x_delta : cur.cur_x;
		nxt.cur_y      = move_y ? cur.cur_y + y_delta : cur.cur_y;
		nxt.error_term = cur.error_term - err_sub + err_add;

		last       = cur.x_major ? (nxt.cur_x == cur.target_x) : (nxt.cur_y == cur.target_y);
		nxt.active = !last;
	end

endmodule
`default_nettype wire

// ----- sv/bresenham_line_stepper.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bresenham line stepper
// Rasterizes a line at most one pixel per command beat: start beats load a line and
// give its first pixel, advance beats give the following pixels.
// Path: a command beat is registered in cmd_s1, then its pixel beat in pixel_q.
// Throughput: one command beat per cycle while the pixel side does not stall; the
//   setup or step logic lies between the command register and the pixel register.
// Reset: arst_n clears the valid flags and the line state; the block is idle.
// ----------------------------------------------------------------------------
module bresenham_line_stepper (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cmd_valid,
	output logic                 cmd_stall,
	input  bls_pkg::cmd_beat_t   cmd,
	output logic                 pixel_valid,
	input  wire                  pixel_stall,
	output bls_pkg::pixel_beat_t pixel
);

	bls_pkg::cmd_beat_t   cmd_s1;
	logic                 valid_s1;
	bls_pkg::line_state_t state_q;
	bls_pkg::pixel_beat_t pixel_q;
	logic                 pixel_valid_q;

	bls_pkg::line_state_t setup_state;
	logic                 setup_last;
	bls_pkg::line_state_t step_state;
	logic                 step_last;

	logic                 advance;
	logic                 fire_s1;
	logic                 is_start;
	logic                 emit;
	logic                 emit_last;
	bls_pkg::line_state_t state_d;

	bls_line_setup u_setup (
		.cmd   (cmd_s1),
		.setup (setup_state),
		.last  (setup_last)
	);

	bls_step_core u_step (
		.cur  (state_q),
		.nxt  (step_state),
		.last (step_last)
	);

	always_comb begin
		advance   = !pixel_valid_q || !pixel_stall;
		fire_s1   = valid_s1 && advance;
		cmd_stall = valid_s1 && !advance;
		is_start  = cmd_s1.func == bls_pkg::FUNC_START;
		// An advance beat on an idle line leaves no pixel and no state change.
		emit      = is_start || state_q.active;
		emit_last = is_start ? setup_last : step_last;
		if (is_start) begin
			state_d = setup_state;
		end else if (state_q.active) begin
			state_d = step_state;
		end else begin
			state_d = state_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= '0;
			pixel_valid_q <= 1'b0;
		end else begin
			if (fire_s1) begin
				state_q <= state_d;
			end
			if (advance) begin
				pixel_valid_q <= fire_s1 && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			pixel_q.pixel_x     <= state_d.cur_x;
			pixel_q.pixel_y     <= state_d.cur_y;
			pixel_q.pixel_color <= state_d.line_color;
			pixel_q.last_pixel  <= emit_last;
		end
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel       = pixel_q;

	// A line that hands out its last pixel is idle afterwards.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && emit && emit_last) |=> !state_q.active)
		else $error("line still active after its last pixel");

	// An advance on an idle line produces no pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && !is_start && !state_q.active) |=> !pixel_valid_q)
		else $error("pixel produced by an advance on an idle line");

	// The command side only stalls while a pixel waits to be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (pixel_valid_q && pixel_stall && valid_s1))
		else $error("command stall without a blocked pixel");

endmodule
`default_nettype wire
